// ===== hw/rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the escape-time pixel evaluator: controller
// states, the command and status groups between controller and datapath, and
// field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned LIMIT_W = 12;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned PROD_W  = 2 * COORD_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 12'd255;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;  // capture c, z = c, count = 0
    logic mul;   // register the three products of z
    logic step;  // advance z, bump the count
    logic emit;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic finish;  // current z escaped or count reached the cap
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer of the evaluator: alternates product and update cycles until the
// datapath reports the end, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output mbe_pkg::cmd_t        cmd,
  input  wire mbe_pkg::status_t status
);

  mbe_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == mbe_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      mbe_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = mbe_pkg::ST_MUL;
        end
      end
      mbe_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = mbe_pkg::ST_UPD;
      end
      mbe_pkg::ST_UPD: begin
        if (status.finish) begin
          if (out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = mbe_pkg::ST_IDLE;
          end else begin
            state_nxt = mbe_pkg::ST_HOLD;
          end
        end else begin
          cmd.step  = 1'b1;
          state_nxt = mbe_pkg::ST_MUL;
        end
      end
      mbe_pkg::ST_HOLD: begin
        // hold the finished item until the result register frees up
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = mbe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbe_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mbe_datapath.sv =====
// ----------------------------------------------------------------------------
// mbe_datapath
// Fixed-point z = z*z + c iteration with saturation, escape test, iteration
// counter, limit register and the registered result with its color levels.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_datapath #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [mbe_pkg::LIMIT_W-1:0]         cfg_wr_data,
  input  wire logic [2*mbe_pkg::COORD_W-1:0]       point,
  input  wire mbe_pkg::cmd_t                       cmd,
  output mbe_pkg::status_t                         status,
  output logic [mbe_pkg::COUNT_W-1:0]              res_count,
  output logic                                     res_inside,
  output logic [mbe_pkg::LEVEL_W-1:0]              res_green,
  output logic [mbe_pkg::LEVEL_W-1:0]              res_blue
);

  localparam int unsigned CW = mbe_pkg::COORD_W;
  localparam int unsigned PW = mbe_pkg::PROD_W;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned MAG_SH = 2 * FRAC_BITS + 2;
  localparam bit CAN_ESC = (MAG_SH <= PW - 1);
  localparam logic [PW-1:0] THRESH = CAN_ESC ? (PW'(1) << MAG_SH) : '0;

  logic [mbe_pkg::LIMIT_W-1:0] limit_r;
  logic signed [CW-1:0]        cr_r, ci_r, zr_r, zi_r;
  logic signed [PW-1:0]        p_rr_r, p_ii_r, p_ri_r;
  logic [mbe_pkg::COUNT_W-1:0] count_r;

  logic signed [PW-1:0] prod_rr, prod_ii, prod_ri;
  logic signed [PW-1:0] diff, diff_sh, ri_sh;
  logic signed [SW-1:0] sum_r, sum_i;
  logic signed [CW-1:0] zr_nxt, zi_nxt;
  logic [PW-1:0]        mag;
  logic [mbe_pkg::COUNT_W-1:0] cap;
  logic                 escaped;
  logic                 in_set;
  logic [8:0]           green9;
  logic [mbe_pkg::LEVEL_W-1:0] green;

  // product cycle
  assign prod_rr = zr_r * zr_r;
  assign prod_ii = zi_r * zi_r;
  assign prod_ri = zr_r * zi_r;

  // update cycle: floor shifts, add c, saturate
  assign diff    = p_rr_r - p_ii_r;
  assign diff_sh = diff >>> FRAC_BITS;
  assign ri_sh   = p_ri_r >>> (FRAC_BITS - 1);
  assign sum_r   = {{2{diff_sh[PW-1]}}, diff_sh} + {{(SW-CW){cr_r[CW-1]}}, cr_r};
  assign sum_i   = {{2{ri_sh[PW-1]}}, ri_sh} + {{(SW-CW){ci_r[CW-1]}}, ci_r};

  always_comb begin
    if (sum_r[SW-1:CW-1] == '0 || sum_r[SW-1:CW-1] == '1) begin
      zr_nxt = sum_r[CW-1:0];
    end else if (sum_r[SW-1]) begin
      zr_nxt = {1'b1, {(CW-1){1'b0}}};
    end else begin
      zr_nxt = {1'b0, {(CW-1){1'b1}}};
    end
    if (sum_i[SW-1:CW-1] == '0 || sum_i[SW-1:CW-1] == '1) begin
      zi_nxt = sum_i[CW-1:0];
    end else if (sum_i[SW-1]) begin
      zi_nxt = {1'b1, {(CW-1){1'b0}}};
    end else begin
      zi_nxt = {1'b0, {(CW-1){1'b1}}};
    end
  end

  // products of the current z give the magnitude of the last iteration's result
  assign mag     = p_rr_r + p_ii_r;
  assign cap     = {1'b0, limit_r} + mbe_pkg::COUNT_W'(2);
  assign escaped = CAN_ESC && (count_r != '0) && (mag > THRESH);
  assign status.finish = escaped || (count_r == cap);

  // color levels
  assign in_set = (count_r > {1'b0, limit_r});
  assign green9 = 9'd256 >> count_r;
  assign green  = (count_r >= mbe_pkg::COUNT_W'(9)) ? '0 : green9[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mbe_pkg::LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r    <= point[CW-1:0];
      ci_r    <= point[2*CW-1:CW];
      zr_r    <= point[CW-1:0];
      zi_r    <= point[2*CW-1:CW];
      count_r <= '0;
    end else if (cmd.step) begin
      zr_r    <= zr_nxt;
      zi_r    <= zi_nxt;
      count_r <= count_r + mbe_pkg::COUNT_W'(1);
    end
    if (cmd.mul) begin
      p_rr_r <= prod_rr;
      p_ii_r <= prod_ii;
      p_ri_r <= prod_ri;
    end
    if (cmd.emit) begin
      res_count  <= count_r;
      res_inside <= in_set;
      res_green  <= in_set ? '0 : green;
      res_blue   <= in_set ? '0 : (8'd255 - green);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mandelbrot_escape_time_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator for one point c: iterates z = z*z + c in fixed point,
// reports the iteration count, the inside flag and green/blue levels.
// ----------------------------------------------------------------------------
// Each iteration is a product step and an update step, and a final test ends the
// item. The block takes one item at a time: in_tready is low until the result
// is handed to the output register, which may stall while out_tready is low.
// The iteration loop holds three 32x32 multipliers.
// Reset (rst_n low, synchronous) empties the output and sets the limit to 255.
`default_nettype none

module mandelbrot_escape_time_pixel #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,  // iteration_limit
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,     // [31:0] point_real, [63:32] point_imag
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,    // [12:0] escape_count, [20:13] green_level,
                                         // [28:21] blue_level, [31:29] zero
  output logic             out_tuser     // [0] inside_set
);

  mbe_pkg::cmd_t    cmd;
  mbe_pkg::status_t status;
  logic [mbe_pkg::COUNT_W-1:0] res_count;
  logic [mbe_pkg::LEVEL_W-1:0] res_green, res_blue;
  logic                        res_inside;

  mbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  mbe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .point       (in_tdata),
    .cmd         (cmd),
    .status      (status),
    .res_count   (res_count),
    .res_inside  (res_inside),
    .res_green   (res_green),
    .res_blue    (res_blue)
  );

  assign out_tdata = {3'b000, res_blue, res_green, res_count};
  assign out_tuser = res_inside;

endmodule

`default_nettype wire
